FILE: rtl/core/crt_pkg.sv
package crt_pkg;

	localparam int SLOTS_DEF = 8;

	localparam logic [31:0] TIMEOUT_RST = 32'd5000;
	localparam logic [3:0]  LIMIT_RST   = 4'd3;
	localparam logic [31:0] HB_RST      = 32'd10000;
	localparam logic [3:0]  RETRY_MAX   = 4'd15;

	localparam logic [1:0] CFG_TIMEOUT     = 2'd0;
	localparam logic [1:0] CFG_RETRY_LIMIT = 2'd1;
	localparam logic [1:0] CFG_HEARTBEAT   = 2'd2;

	typedef enum logic [1:0] {
		FN_SEND = 2'd0,
		FN_RESP = 2'd1,
		FN_KEEP = 2'd2,
		FN_TICK = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		KD_ACCEPT     = 4'd0,
		KD_FULL       = 4'd1,
		KD_MATCH_OK   = 4'd2,
		KD_MATCH_FAIL = 4'd3,
		KD_UNMATCHED  = 4'd4,
		KD_RETRY      = 4'd5,
		KD_EXPIRED    = 4'd6,
		KD_HEARTBEAT  = 4'd7,
		KD_DONE       = 4'd8
	} kind_t;

	typedef enum logic [1:0] {
		EM_ONE  = 2'd0,
		EM_SLOT = 2'd1,
		EM_HB   = 2'd2,
		EM_DONE = 2'd3
	} emit_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISP,
		ST_SEND_UPD,
		ST_RSP_RD,
		ST_RSP_CHK,
		ST_RSP_UPD,
		ST_ONE,
		ST_KEEP_UPD,
		ST_T1_RD,
		ST_T1_CHK,
		ST_T_FIN,
		ST_T2_RD,
		ST_T2_CHK,
		ST_HB,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [31:0] id;
		logic [7:0]  tag;
		logic [31:0] stamp;
		logic [3:0]  retries;
	} ent_t;

	typedef struct packed {
		logic      in_ready;
		logic      ctx_clr;
		logic      idx_clr;
		logic      idx_inc;
		logic      rd_req;
		logic      send_upd;
		logic      rsp_chk;
		logic      rsp_upd;
		logic      keep_upd;
		logic      drop_acc;
		logic      tick_fin;
		logic      slot_upd;
		logic      emit;
		emit_sel_t emit_sel;
		logic      emit_last;
	} cmd_t;

	typedef struct packed {
		logic  in_valid;
		func_t func;
		logic  hit;
		logic  expired;
		logic  idx_last;
		logic  out_free;
		logic  hb_due;
	} sts_t;

endpackage

FILE: rtl/core/crt_ifs.sv
interface crt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [31:0] cmd_id;
	logic [7:0]  action_tag;
	logic        resp_ok;
	logic        resp_pong;
	logic [31:0] now_ms;

	modport source (output valid, func, cmd_id, action_tag, resp_ok, resp_pong, now_ms,
		input ready);
	modport sink (input valid, func, cmd_id, action_tag, resp_ok, resp_pong, now_ms,
		output ready);
endinterface

interface crt_res_if;
	logic        valid;
	logic        ready;
	logic [3:0]  kind;
	logic [2:0]  slot;
	logic [7:0]  out_tag;
	logic [31:0] out_id;
	logic [3:0]  retries;
	logic        link_up;
	logic [3:0]  pending;
	logic        last;

	modport source (output valid, kind, slot, out_tag, out_id, retries, link_up, pending, last,
		input ready);
	modport sink (input valid, kind, slot, out_tag, out_id, retries, link_up, pending, last,
		output ready);
endinterface

interface crt_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/crt_ctrl.sv
module crt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  crt_pkg::sts_t sts,
	output crt_pkg::cmd_t cmd
);

	crt_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crt_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			crt_pkg::ST_IDLE: begin
				if (sts.in_valid) state_nxt = crt_pkg::ST_DISP;
			end
			crt_pkg::ST_DISP: begin
				unique case (sts.func)
					crt_pkg::FN_SEND: state_nxt = crt_pkg::ST_SEND_UPD;
					crt_pkg::FN_RESP: state_nxt = crt_pkg::ST_RSP_RD;
					crt_pkg::FN_KEEP: state_nxt = crt_pkg::ST_KEEP_UPD;
					crt_pkg::FN_TICK: state_nxt = crt_pkg::ST_T1_RD;
					default:          state_nxt = crt_pkg::ST_IDLE;
				endcase
			end
			crt_pkg::ST_SEND_UPD: state_nxt = crt_pkg::ST_ONE;
			crt_pkg::ST_RSP_RD:   state_nxt = crt_pkg::ST_RSP_CHK;
			crt_pkg::ST_RSP_CHK: begin
				if (sts.hit || sts.idx_last) state_nxt = crt_pkg::ST_RSP_UPD;
				else state_nxt = crt_pkg::ST_RSP_RD;
			end
			crt_pkg::ST_RSP_UPD: state_nxt = crt_pkg::ST_ONE;
			crt_pkg::ST_ONE: begin
				if (sts.out_free) state_nxt = crt_pkg::ST_IDLE;
			end
			crt_pkg::ST_KEEP_UPD: state_nxt = crt_pkg::ST_DONE;
			crt_pkg::ST_T1_RD:    state_nxt = crt_pkg::ST_T1_CHK;
			crt_pkg::ST_T1_CHK: begin
				if (sts.idx_last) state_nxt = crt_pkg::ST_T_FIN;
				else state_nxt = crt_pkg::ST_T1_RD;
			end
			crt_pkg::ST_T_FIN: state_nxt = crt_pkg::ST_T2_RD;
			crt_pkg::ST_T2_RD: state_nxt = crt_pkg::ST_T2_CHK;
			crt_pkg::ST_T2_CHK: begin
				if (!sts.expired || sts.out_free) begin
					if (sts.idx_last) state_nxt = crt_pkg::ST_HB;
					else state_nxt = crt_pkg::ST_T2_RD;
				end
			end
			crt_pkg::ST_HB: begin
				if (!sts.hb_due || sts.out_free) state_nxt = crt_pkg::ST_DONE;
			end
			crt_pkg::ST_DONE: begin
				if (sts.out_free) state_nxt = crt_pkg::ST_IDLE;
			end
			default: state_nxt = crt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.emit_sel = crt_pkg::EM_ONE;
		unique case (state_q)
			crt_pkg::ST_IDLE: cmd.in_ready = 1'b1;
			crt_pkg::ST_DISP: begin
				cmd.ctx_clr = 1'b1;
				cmd.idx_clr = 1'b1;
			end
			crt_pkg::ST_SEND_UPD: cmd.send_upd = 1'b1;
			crt_pkg::ST_RSP_RD:   cmd.rd_req = 1'b1;
			crt_pkg::ST_RSP_CHK: begin
				cmd.rsp_chk = 1'b1;
				cmd.idx_inc = !sts.hit && !sts.idx_last;
			end
			crt_pkg::ST_RSP_UPD: cmd.rsp_upd = 1'b1;
			crt_pkg::ST_ONE: begin
				cmd.emit      = sts.out_free;
				cmd.emit_sel  = crt_pkg::EM_ONE;
				cmd.emit_last = 1'b1;
			end
			crt_pkg::ST_KEEP_UPD: cmd.keep_upd = 1'b1;
			crt_pkg::ST_T1_RD:    cmd.rd_req = 1'b1;
			crt_pkg::ST_T1_CHK: begin
				cmd.drop_acc = 1'b1;
				cmd.idx_inc  = !sts.idx_last;
			end
			crt_pkg::ST_T_FIN: begin
				cmd.tick_fin = 1'b1;
				cmd.idx_clr  = 1'b1;
			end
			crt_pkg::ST_T2_RD: cmd.rd_req = 1'b1;
			crt_pkg::ST_T2_CHK: begin
				cmd.emit     = sts.expired && sts.out_free;
				cmd.emit_sel = crt_pkg::EM_SLOT;
				cmd.slot_upd = sts.expired && sts.out_free;
				cmd.idx_inc  = (!sts.expired || sts.out_free) && !sts.idx_last;
			end
			crt_pkg::ST_HB: begin
				cmd.emit     = sts.hb_due && sts.out_free;
				cmd.emit_sel = crt_pkg::EM_HB;
			end
			crt_pkg::ST_DONE: begin
				cmd.emit      = sts.out_free;
				cmd.emit_sel  = crt_pkg::EM_DONE;
				cmd.emit_last = 1'b1;
			end
			default: cmd.in_ready = 1'b0;
		endcase
	end

endmodule

FILE: rtl/core/crt_dp.sv
module crt_dp #(
	parameter int SLOTS = crt_pkg::SLOTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	crt_req_if.sink       req,
	crt_res_if.source     res,
	crt_cfg_if.sink       cfg,
	input  crt_pkg::cmd_t cmd,
	output crt_pkg::sts_t sts
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	crt_pkg::func_t func_q;
	logic [31:0]    id_q;
	logic [7:0]     tag_q;
	logic           ok_q;
	logic           pong_q;
	logic [31:0]    now_q;

	logic [31:0] timeout_q;
	logic [3:0]  limit_q;
	logic [31:0] hb_ms_q;

	logic [SLOTS-1:0] valid_q;
	logic [CW-1:0]    count_q;
	logic             conn_q;
	logic [31:0]      hb_stamp_q;

	crt_pkg::ent_t mem [SLOTS];
	crt_pkg::ent_t rd_q;
	logic          mem_we;
	logic [IW-1:0] mem_wa;
	crt_pkg::ent_t mem_wd;

	logic [IW-1:0] idx_q;
	logic          hit_q;
	logic [IW-1:0] hit_idx_q;
	logic [CW-1:0] drops_q;
	logic          hb_due_q;

	logic          out_valid_q;
	logic [3:0]    kind_q;
	logic [2:0]    slot_q;
	logic [7:0]    tag_out_q;
	logic [31:0]   id_out_q;
	logic [3:0]    retries_q;
	logic          link_q;
	logic [3:0]    pending_q;
	logic          last_q;

	logic          accept;
	logic          has_free;
	logic [IW-1:0] free_idx;
	logic [31:0]   age_slot;
	logic [31:0]   age_hb;
	logic          expired;
	logic [3:0]    sat;
	logic          drop;
	logic          hit;
	logic          link;
	logic          out_free;

	crt_pkg::kind_t kind_nxt;
	logic [2:0]     slot_nxt;
	logic [7:0]     tag_nxt;
	logic [31:0]    id_nxt;
	logic [3:0]     retries_nxt;

	assign accept   = req.valid && cmd.in_ready;
	assign req.ready = cmd.in_ready;
	assign cfg.ready = 1'b1;

	always_comb begin
		has_free = 1'b0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				has_free = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	assign age_slot = now_q - rd_q.stamp;
	assign age_hb   = now_q - hb_stamp_q;
	assign expired  = valid_q[idx_q] && (age_slot > timeout_q);
	assign sat      = (rd_q.retries == crt_pkg::RETRY_MAX) ? crt_pkg::RETRY_MAX
		: rd_q.retries + 4'd1;
	assign drop     = sat >= limit_q;
	assign hit      = valid_q[idx_q] && (rd_q.id == id_q);
	assign link     = conn_q && ({1'b0, age_hb} < {hb_ms_q, 1'b0});
	assign out_free = !out_valid_q || res.ready;

	assign sts.in_valid = req.valid;
	assign sts.func     = func_q;
	assign sts.hit      = hit;
	assign sts.expired  = expired;
	assign sts.idx_last = idx_q == IW'(SLOTS - 1);
	assign sts.out_free = out_free;
	assign sts.hb_due   = hb_due_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= crt_pkg::func_t'(req.func);
			id_q   <= req.cmd_id;
			tag_q  <= req.action_tag;
			ok_q   <= req.resp_ok;
			pong_q <= req.resp_pong;
			now_q  <= req.now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= crt_pkg::TIMEOUT_RST;
			limit_q   <= crt_pkg::LIMIT_RST;
			hb_ms_q   <= crt_pkg::HB_RST;
		end else if (cfg.valid) begin
			if (cfg.index == crt_pkg::CFG_TIMEOUT) timeout_q <= cfg.data;
			if (cfg.index == crt_pkg::CFG_RETRY_LIMIT) limit_q <= cfg.data[3:0];
			if (cfg.index == crt_pkg::CFG_HEARTBEAT) hb_ms_q <= cfg.data;
		end
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_q;
		mem_wd = '{id: rd_q.id, tag: rd_q.tag, stamp: now_q, retries: sat};
		if (cmd.send_upd && has_free) begin
			mem_we = 1'b1;
			mem_wa = free_idx;
			mem_wd = '{id: id_q, tag: tag_q, stamp: now_q, retries: 4'd0};
		end else if (cmd.slot_upd && !drop) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (cmd.rd_req) rd_q <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			count_q    <= '0;
			conn_q     <= 1'b0;
			hb_stamp_q <= '0;
			idx_q      <= '0;
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
			drops_q    <= '0;
			hb_due_q   <= 1'b0;
		end else begin
			if (cmd.idx_clr) idx_q <= '0;
			else if (cmd.idx_inc) idx_q <= idx_q + IW'(1);
			if (cmd.ctx_clr) begin
				hit_q   <= 1'b0;
				drops_q <= '0;
			end
			if (cmd.send_upd) begin
				hit_q     <= has_free;
				hit_idx_q <= free_idx;
				if (has_free) begin
					valid_q[free_idx] <= 1'b1;
					count_q           <= count_q + CW'(1);
				end
			end
			if (cmd.rsp_chk && hit) begin
				hit_q     <= 1'b1;
				hit_idx_q <= idx_q;
			end
			if (cmd.rsp_upd) begin
				if (hit_q) begin
					valid_q[hit_idx_q] <= 1'b0;
					count_q            <= count_q - CW'(1);
				end
				if ((hit_q && ok_q) || pong_q) conn_q <= 1'b1;
			end
			if (cmd.keep_upd) conn_q <= 1'b1;
			if (cmd.drop_acc && expired && drop) drops_q <= drops_q + CW'(1);
			if (cmd.tick_fin) begin
				count_q  <= count_q - drops_q;
				hb_due_q <= age_hb > hb_ms_q;
				if (drops_q != '0) conn_q <= 1'b0;
				if (age_hb > hb_ms_q) hb_stamp_q <= now_q;
			end
			if (cmd.slot_upd && drop) valid_q[idx_q] <= 1'b0;
		end
	end

	always_comb begin
		kind_nxt    = crt_pkg::KD_DONE;
		slot_nxt    = '0;
		tag_nxt     = '0;
		id_nxt      = '0;
		retries_nxt = '0;
		unique case (cmd.emit_sel)
			crt_pkg::EM_ONE: begin
				if (func_q == crt_pkg::FN_SEND) begin
					id_nxt = id_q;
					if (hit_q) begin
						kind_nxt = crt_pkg::KD_ACCEPT;
						slot_nxt = 3'(hit_idx_q);
						tag_nxt  = tag_q;
					end else begin
						kind_nxt = crt_pkg::KD_FULL;
					end
				end else if (hit_q) begin
					kind_nxt    = ok_q ? crt_pkg::KD_MATCH_OK : crt_pkg::KD_MATCH_FAIL;
					slot_nxt    = 3'(hit_idx_q);
					tag_nxt     = rd_q.tag;
					id_nxt      = rd_q.id;
					retries_nxt = rd_q.retries;
				end else begin
					kind_nxt = crt_pkg::KD_UNMATCHED;
					id_nxt   = id_q;
				end
			end
			crt_pkg::EM_SLOT: begin
				kind_nxt    = drop ? crt_pkg::KD_EXPIRED : crt_pkg::KD_RETRY;
				slot_nxt    = 3'(idx_q);
				tag_nxt     = rd_q.tag;
				id_nxt      = rd_q.id;
				retries_nxt = sat;
			end
			crt_pkg::EM_HB:   kind_nxt = crt_pkg::KD_HEARTBEAT;
			crt_pkg::EM_DONE: kind_nxt = crt_pkg::KD_DONE;
			default:          kind_nxt = crt_pkg::KD_DONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind_q    <= kind_nxt;
			slot_q    <= slot_nxt;
			tag_out_q <= tag_nxt;
			id_out_q  <= id_nxt;
			retries_q <= retries_nxt;
			link_q    <= link;
			pending_q <= 4'(count_q);
			last_q    <= cmd.emit_last;
		end
	end

	assign res.valid   = out_valid_q;
	assign res.kind    = kind_q;
	assign res.slot    = slot_q;
	assign res.out_tag = tag_out_q;
	assign res.out_id  = id_out_q;
	assign res.retries = retries_q;
	assign res.link_up = link_q;
	assign res.pending = pending_q;
	assign res.last    = last_q;

endmodule

FILE: rtl/core/command_retry_tracker.sv
// Send and keepalive results follow the input transfer; a response waits for a slot
// search that stops at a hit, and a tick for two passes over the slots plus output stalls.
// One item at a time: the next transfer is taken once the last result of the item is
// loaded. The single read port of the slot memory, read one entry at a time, paces the
// response search and the two tick passes.
// Reset: clears valid bits, pending count, link state and sets config defaults.
module command_retry_tracker #(
	parameter int SLOTS = crt_pkg::SLOTS_DEF
) (
	input logic     clk,
	input logic     arst_n,
	crt_req_if.sink   req,
	crt_res_if.source res,
	crt_cfg_if.sink   cfg
);

	crt_pkg::cmd_t cmd;
	crt_pkg::sts_t sts;

	crt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	crt_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.res    (res),
		.cfg    (cfg),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

FILE: rtl/core/crt_checker.sv
module crt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic [3:0] res_kind,
	input logic [2:0] res_slot,
	input logic [7:0] res_tag,
	input logic [3:0] res_retries,
	input logic       res_last
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_kind) && $stable(res_last))
		else $error("result changed while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("input taken while an item is in work");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_kind == crt_pkg::KD_DONE) |-> res_last)
		else $error("done result not marked last");

	a_tick_mid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_kind == crt_pkg::KD_RETRY || res_kind == crt_pkg::KD_EXPIRED
		|| res_kind == crt_pkg::KD_HEARTBEAT) |-> !res_last)
		else $error("tick result marked last before done");

	a_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_kind == crt_pkg::KD_FULL || res_kind == crt_pkg::KD_UNMATCHED
		|| res_kind == crt_pkg::KD_HEARTBEAT || res_kind == crt_pkg::KD_DONE)
		|-> res_slot == 3'd0 && res_tag == 8'd0 && res_retries == 4'd0)
		else $error("slot fields set on a result without a slot");

endmodule

bind command_retry_tracker crt_checker u_crt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.res_kind    (res.kind),
	.res_slot    (res.slot),
	.res_tag     (res.out_tag),
	.res_retries (res.retries),
	.res_last    (res.last)
);

FILE: dv/command_retry_tracker_tb.sv
`timescale 1ns / 100ps

module command_retry_tracker_tb;

	localparam int SLOTS = crt_pkg::SLOTS_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 4 * SLOTS + 20;
	localparam logic [1:0] CFG_SPARE = 2'd3;

	typedef struct packed {
		crt_pkg::kind_t kind;
		logic [2:0]     slot;
		logic [7:0]     tag;
		logic [31:0]    id;
		logic [3:0]     retries;
		logic           link_up;
		logic [3:0]     pending;
		logic           last;
	} tracker_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	crt_req_if req ();
	crt_res_if res ();
	crt_cfg_if cfg ();

	command_retry_tracker #(.SLOTS(SLOTS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.res(res),
		.cfg(cfg)
	);

	logic [31:0] timeout_ms = crt_pkg::TIMEOUT_RST;
	logic [3:0]  retry_limit = crt_pkg::LIMIT_RST;
	logic [31:0] heartbeat_ms = crt_pkg::HB_RST;
	logic        entry_live [SLOTS] = '{default: 1'b0};
	logic [31:0] entry_id [SLOTS];
	logic [7:0]  entry_tag [SLOTS];
	logic [31:0] entry_stamp [SLOTS];
	logic [3:0]  entry_retries [SLOTS];
	int          live_count = 0;
	logic        connected = 1'b0;
	logic [31:0] beat_stamp = '0;

	tracker_result_t awaited_results [$];
	int unsigned cycle_count = 0;
	int error_count = 0;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	logic [31:0] wall_ms = '0;
	logic [31:0] pace_ms = 32'd1000;
	logic [31:0] issued_ids [$];

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk)
		res.ready <= ($urandom_range(99) >= sink_stall_pct);

	function automatic tracker_result_t slot_result(crt_pkg::kind_t k, int s,
			logic [7:0] t, logic [31:0] i, logic [3:0] r);
		tracker_result_t x;
		x = '0;
		x.kind = k;
		x.slot = s[2:0];
		x.tag = t;
		x.id = i;
		x.retries = r;
		return x;
	endfunction

	task automatic track_command(input crt_pkg::func_t fn, input logic [31:0] id,
			input logic [7:0] tag, input logic ok, input logic pong, input logic [31:0] now);
		tracker_result_t batch [$];
		int pick;
		int i;
		logic [31:0] age;
		logic link;
		pick = -1;
		case (fn)
		crt_pkg::FN_SEND: begin
			if (live_count < SLOTS)
				for (i = 0; i < SLOTS && pick < 0; i++)
					if (!entry_live[i])
						pick = i;
			if (pick < 0) begin
				batch.push_back(slot_result(crt_pkg::KD_FULL, 0, '0, id, '0));
			end else begin
				entry_live[pick] = 1'b1;
				entry_id[pick] = id;
				entry_tag[pick] = tag;
				entry_stamp[pick] = now;
				entry_retries[pick] = '0;
				live_count++;
				batch.push_back(slot_result(crt_pkg::KD_ACCEPT, pick, tag, id, '0));
			end
		end
		crt_pkg::FN_RESP: begin
			for (i = 0; i < SLOTS && pick < 0; i++)
				if (entry_live[i] && entry_id[i] == id)
					pick = i;
			if (pick < 0) begin
				batch.push_back(slot_result(crt_pkg::KD_UNMATCHED, 0, '0, id, '0));
			end else begin
				entry_live[pick] = 1'b0;
				if (live_count > 0)
					live_count--;
				if (ok)
					connected = 1'b1;
				batch.push_back(slot_result(
					ok ? crt_pkg::KD_MATCH_OK : crt_pkg::KD_MATCH_FAIL, pick,
					entry_tag[pick], entry_id[pick], entry_retries[pick]));
			end
			if (pong)
				connected = 1'b1;
		end
		crt_pkg::FN_KEEP: begin
			connected = 1'b1;
			batch.push_back(slot_result(crt_pkg::KD_DONE, 0, '0, '0, '0));
		end
		default: begin
			for (i = 0; i < SLOTS; i++) begin
				if (!entry_live[i])
					continue;
				age = now - entry_stamp[i];
				if (age <= timeout_ms)
					continue;
				if (entry_retries[i] < crt_pkg::RETRY_MAX)
					entry_retries[i]++;
				if (entry_retries[i] >= retry_limit) begin
					entry_live[i] = 1'b0;
					if (live_count > 0)
						live_count--;
					connected = 1'b0;
					batch.push_back(slot_result(crt_pkg::KD_EXPIRED, i, entry_tag[i],
						entry_id[i], entry_retries[i]));
				end else begin
					entry_stamp[i] = now;
					batch.push_back(slot_result(crt_pkg::KD_RETRY, i, entry_tag[i],
						entry_id[i], entry_retries[i]));
				end
			end
			age = now - beat_stamp;
			if (age > heartbeat_ms) begin
				beat_stamp = now;
				batch.push_back(slot_result(crt_pkg::KD_HEARTBEAT, 0, '0, '0, '0));
			end
			batch.push_back(slot_result(crt_pkg::KD_DONE, 0, '0, '0, '0));
		end
		endcase
		age = now - beat_stamp;
		link = connected && ({1'b0, age} < {heartbeat_ms, 1'b0});
		foreach (batch[k]) begin
			batch[k].link_up = link;
			batch[k].pending = live_count[3:0];
			batch[k].last = (k == batch.size() - 1);
			awaited_results.push_back(batch[k]);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && req.valid && req.ready)
			track_command(crt_pkg::func_t'(req.func), req.cmd_id, req.action_tag,
				req.resp_ok, req.resp_pong, req.now_ms);
		if (arst_n && cfg.valid && cfg.ready) begin
			case (cfg.index)
			crt_pkg::CFG_TIMEOUT: timeout_ms = cfg.data;
			crt_pkg::CFG_RETRY_LIMIT: retry_limit = cfg.data[3:0];
			crt_pkg::CFG_HEARTBEAT: heartbeat_ms = cfg.data;
			default: ;
			endcase
		end
	end

	function automatic void match_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin
		tracker_result_t want;
		if (arst_n && res.valid && res.ready) begin
			if (awaited_results.size() == 0) begin
				$error("unexpected result: kind %0d slot %0d id %h", res.kind, res.slot,
					res.out_id);
				error_count++;
			end else begin
				want = awaited_results.pop_front();
				match_field("kind", want.kind, res.kind);
				match_field("slot", want.slot, res.slot);
				match_field("out_tag", want.tag, res.out_tag);
				match_field("out_id", want.id, res.out_id);
				match_field("retries", want.retries, res.retries);
				match_field("link_up", want.link_up, res.link_up);
				match_field("pending", want.pending, res.pending);
				match_field("last", want.last, res.last);
			end
		end
	end

	task automatic issue_command(input crt_pkg::func_t fn, input logic [31:0] id,
			input logic [7:0] tag, input logic ok, input logic pong, input logic [31:0] now);
		if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < src_idle_pct)
				@(posedge clk);
		end
		req.valid <= 1'b1;
		req.func <= fn;
		req.cmd_id <= id;
		req.action_tag <= tag;
		req.resp_ok <= ok;
		req.resp_pong <= pong;
		req.now_ms <= now;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
	endtask

	task automatic wait_drained;
		req.valid <= 1'b0;
		@(posedge clk);
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_registers(input logic [31:0] tmo, input logic [3:0] lim,
			input logic [31:0] beat, input bit stray);
		logic [1:0] reg_index [4] = '{crt_pkg::CFG_TIMEOUT, crt_pkg::CFG_RETRY_LIMIT,
			crt_pkg::CFG_HEARTBEAT, CFG_SPARE};
		logic [31:0] reg_value [4];
		int k;
		reg_value = '{tmo, {28'($urandom()), lim}, beat, $urandom()};
		for (k = 0; k < 4; k++) begin
			if (k == 3 && !stray)
				break;
			cfg.valid <= 1'b1;
			cfg.index <= reg_index[k];
			cfg.data <= reg_value[k];
			@(posedge clk);
			while (!cfg.ready)
				@(posedge clk);
		end
		cfg.valid <= 1'b0;
	endtask

	task automatic random_command;
		int roll;
		logic [31:0] id;
		logic [31:0] now;
		roll = $urandom_range(99);
		wall_ms += $urandom_range(0, pace_ms);
		now = ($urandom_range(99) < 5) ? $urandom() : wall_ms;
		if (roll < 35) begin
			if (issued_ids.size() != 0 && $urandom_range(9) == 0)
				id = issued_ids[$urandom_range(issued_ids.size() - 1)];
			else
				id = $urandom();
			issued_ids.push_back(id);
			if (issued_ids.size() > 16)
				void'(issued_ids.pop_front());
			issue_command(crt_pkg::FN_SEND, id, 8'($urandom()), 1'($urandom()),
				1'($urandom()), now);
		end else if (roll < 65) begin
			if (issued_ids.size() != 0 && $urandom_range(99) < 80)
				id = issued_ids[$urandom_range(issued_ids.size() - 1)];
			else
				id = $urandom();
			issue_command(crt_pkg::FN_RESP, id, 8'($urandom()), 1'($urandom()),
				1'($urandom()), now);
		end else if (roll < 75) begin
			issue_command(crt_pkg::FN_KEEP, $urandom(), 8'($urandom()), 1'($urandom()),
				1'($urandom()), now);
		end else begin
			issue_command(crt_pkg::FN_TICK, $urandom(), 8'($urandom()), 1'($urandom()),
				1'($urandom()), now);
		end
	endtask

	task automatic test_directed;
		int k;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		issue_command(crt_pkg::FN_KEEP, 32'd0, 8'd0, 1'b0, 1'b0, 32'd0);
		issue_command(crt_pkg::FN_SEND, 32'h0000_0000, 8'h00, 1'b1, 1'b1, 32'd0);
		issue_command(crt_pkg::FN_SEND, 32'hFFFF_FFFF, 8'hFF, 1'b0, 1'b0, 32'd100);
		issue_command(crt_pkg::FN_RESP, 32'h0BAD_F00D, 8'h00, 1'b0, 1'b1, 32'd200);
		issue_command(crt_pkg::FN_RESP, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0, 32'd300);
		issue_command(crt_pkg::FN_RESP, 32'h0000_0000, 8'h00, 1'b1, 1'b0, 32'd400);
		for (k = 0; k <= SLOTS; k++)
			issue_command(crt_pkg::FN_SEND, 32'hA000_0000 + k, 8'(k * 37), k[0], k[1],
				32'd1000);
		issue_command(crt_pkg::FN_TICK, 32'd0, 8'd0, 1'b0, 1'b0, 32'd6000);
		issue_command(crt_pkg::FN_TICK, 32'd0, 8'd0, 1'b0, 1'b0, 32'd6001);
		issue_command(crt_pkg::FN_TICK, 32'd0, 8'd0, 1'b0, 1'b0, 32'd12002);
		issue_command(crt_pkg::FN_TICK, 32'd0, 8'd0, 1'b0, 1'b0, 32'd22003);
		issue_command(crt_pkg::FN_SEND, 32'h5A5A_5A5A, 8'hA5, 1'b0, 1'b0, 32'hFFFF_FF00);
		issue_command(crt_pkg::FN_TICK, 32'd0, 8'd0, 1'b0, 1'b0, 32'h0000_2000);
		issue_command(crt_pkg::FN_RESP, 32'h5A5A_5A5A, 8'd0, 1'b1, 1'b0, 32'h0000_2001);
		wall_ms = 32'h0000_2001;
		wait_drained;
	endtask

	task automatic test_register_extremes;
		int k;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		set_registers(32'd0, 4'd0, 32'd0, 1'b1);
		pace_ms = 32'd3;
		for (k = 0; k < 15; k++)
			random_command();
		wait_drained;
		set_registers(32'hFFFF_FFFF, 4'd15, 32'hFFFF_FFFF, 1'b1);
		pace_ms = 32'd50000;
		for (k = 0; k < 15; k++)
			random_command();
		wait_drained;
	endtask

	task automatic test_drain_pacing;
		int k;
		src_idle_pct = 0;
		sink_stall_pct = 30;
		set_registers(32'd800, 4'd2, 32'd1500, 1'b0);
		pace_ms = 32'd500;
		for (k = 0; k < 20; k++) begin
			random_command();
			wait_drained;
		end
	endtask

	task automatic test_random_traffic(input int src_pct, input int sink_pct,
			input logic [31:0] tmo, input logic [3:0] lim, input logic [31:0] beat,
			input logic [31:0] pace, input int count);
		int k;
		set_registers(tmo, lim, beat, 1'b0);
		src_idle_pct = src_pct;
		sink_stall_pct = sink_pct;
		pace_ms = pace;
		for (k = 0; k < count; k++)
			random_command();
		wait_drained;
	endtask

	initial begin
		req.valid = 1'b0;
		req.func = crt_pkg::FN_SEND;
		req.cmd_id = '0;
		req.action_tag = '0;
		req.resp_ok = 1'b0;
		req.resp_pong = 1'b0;
		req.now_ms = '0;
		cfg.valid = 1'b0;
		cfg.index = crt_pkg::CFG_TIMEOUT;
		cfg.data = '0;
		res.ready = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_register_extremes();
		test_drain_pacing();
		test_random_traffic(0, 0, 32'd5000, 4'd3, 32'd10000, 32'd2000, 60);
		test_random_traffic(56, 0, 32'd300, 4'd1, 32'd700, 32'd200, 60);
		test_random_traffic(0, 56, 32'd1, 4'd15, 32'd1, 32'd3, 60);
		test_random_traffic(14, 14, 32'd2000, 4'd6, 32'd4000, 32'd900, 60);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
